/* hdl/rxts_pkg.sv */
package rxts_pkg;

  // Field widths of the timestamp items
  localparam int SEC_W       = 40;
  localparam int NSEC_W      = 30;
  localparam int RAW_W       = 13;
  // Internal nanosecond width: room for one second plus a few ticks
  localparam int NSEC_INT_W  = 31;

  localparam int CLOCK_PERIOD_PS_DEF = 8000;
  localparam int PS_PER_NS           = 1000;

  localparam logic [NSEC_INT_W-1:0] NS_PER_SEC = NSEC_INT_W'(1000000000);

  // Phase width for a given period: holds values up to twice the period
  function automatic int phase_width(input int period_ps);
    return $clog2(period_ps) + 1;
  endfunction

  typedef struct packed {
    logic [SEC_W-1:0]  seconds_in;
    logic [NSEC_W-1:0] rising_nsec;
    logic [RAW_W-1:0]  meas_phase;
    logic              counter_ahead;
  } in_t;

  typedef struct packed {
    logic [SEC_W-1:0]  seconds_out;
    logic [NSEC_W-1:0] nsec_out;
    logic [RAW_W-1:0]  phase_out;
    logic [RAW_W-1:0]  raw_phase_out;
  } out_t;

  // Per-item context carried down the pipeline
  typedef struct packed {
    logic [SEC_W-1:0]      sec;
    logic [NSEC_INT_W-1:0] nsec;
    logic [RAW_W-1:0]      raw;
    logic                  ahead;
    logic                  fall;    // falling-edge values selected
    logic                  borrow;  // falling count borrowed a second
  } ctx_t;

endpackage

/* hdl/rx_timestamp_linearizer.sv */
// Receive timestamp linearizer.
// Input channel (item, item_valid, item_stall) takes one coarse timestamp:
// seconds, rising-edge nanoseconds, raw phase and the counter-ahead flag.
// Output channel (result, result_valid, result_stall) gives the merged
// timestamp: seconds, nanoseconds, fine phase and the raw phase unchanged.
// tp_write_en / tp_write_data load the transition point; write it only while
// no item is in flight.
// Four register stages: phase reduction, unwrap and edge select, falling
// edge merge, nanosecond carry. An accepted item passes through them in
// that order to result; one item is accepted per cycle when the output is
// not stalled.
// Each stage has its own valid bit and loads whenever it is empty or its
// successor moves, so bubbles close up under a stall and items are neither
// lost nor repeated. item_stall rises only once every stage holds an item.
// Synchronous reset empties all stages and clears the transition point to 0.
module rx_timestamp_linearizer
  import rxts_pkg::*;
#(
  parameter int CLOCK_PERIOD_PS = CLOCK_PERIOD_PS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_stall,
  input  in_t              item,
  output logic             result_valid,
  input  logic             result_stall,
  output out_t             result,
  input  logic             tp_write_en,
  input  logic [RAW_W-1:0] tp_write_data
);

  localparam int PH_W = phase_width(CLOCK_PERIOD_PS);

  logic [RAW_W-1:0] tp;

  logic            s1_ready, s2_ready, s3_ready, s4_ready;
  logic            s1_valid, s2_valid, s3_valid;
  ctx_t            s1_ctx, s2_ctx, s3_ctx;
  logic [PH_W-1:0] s1_ph, s1_tp;
  logic [PH_W-1:0] s2_phase, s3_phase;

  // Transition point register
  always_ff @(posedge clk) begin
    if (rst) begin
      tp <= '0;
    end else if (tp_write_en) begin
      tp <= tp_write_data;
    end
  end

  assign item_stall = !s1_ready;

  rxts_reduce #(.CLOCK_PERIOD_PS(CLOCK_PERIOD_PS)) u_reduce (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (item_valid),
    .in_ready  (s1_ready),
    .item      (item),
    .tp        (tp),
    .out_valid (s1_valid),
    .out_ready (s2_ready),
    .ctx       (s1_ctx),
    .ph        (s1_ph),
    .tp_red    (s1_tp)
  );

  rxts_unwrap #(.CLOCK_PERIOD_PS(CLOCK_PERIOD_PS)) u_unwrap (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s1_valid),
    .in_ready  (s2_ready),
    .ctx_in    (s1_ctx),
    .ph        (s1_ph),
    .tp_red    (s1_tp),
    .out_valid (s2_valid),
    .out_ready (s3_ready),
    .ctx       (s2_ctx),
    .phase     (s2_phase)
  );

  rxts_merge #(.CLOCK_PERIOD_PS(CLOCK_PERIOD_PS)) u_merge (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s2_valid),
    .in_ready  (s3_ready),
    .ctx_in    (s2_ctx),
    .phase_in  (s2_phase),
    .out_valid (s3_valid),
    .out_ready (s4_ready),
    .ctx       (s3_ctx),
    .phase     (s3_phase)
  );

  rxts_carry #(.CLOCK_PERIOD_PS(CLOCK_PERIOD_PS)) u_carry (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s3_valid),
    .in_ready  (s4_ready),
    .ctx_in    (s3_ctx),
    .phase_in  (s3_phase),
    .out_valid (result_valid),
    .out_ready (!result_stall),
    .result    (result)
  );

  // An accepted item lands in the first stage
  a_accept_loads: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall |=> s1_valid)
    else $error("accepted item did not reach first stage");

  // Input stalls only when the first stage is occupied
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> s1_valid)
    else $error("input stalled with empty first stage");

  // Nanoseconds always below one second after the carry stage
  a_nsec_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (NSEC_INT_W'(result.nsec_out) < NS_PER_SEC))
    else $error("nsec_out out of range");

  // Fine phase lies within one period where it fits the field
  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (CLOCK_PERIOD_PS >= (2 ** RAW_W)) ||
                     (int'(result.phase_out) < CLOCK_PERIOD_PS))
    else $error("phase_out out of range");

endmodule

/* hdl/rxts_reduce.sv */
module rxts_reduce
  import rxts_pkg::*;
#(
  parameter int CLOCK_PERIOD_PS = CLOCK_PERIOD_PS_DEF,
  localparam int PH_W = phase_width(CLOCK_PERIOD_PS)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_t              item,
  input  logic [RAW_W-1:0] tp,
  output logic             out_valid,
  input  logic             out_ready,
  output ctx_t             ctx,
  output logic [PH_W-1:0]  ph,
  output logic [PH_W-1:0]  tp_red
);

  localparam int RW    = (PH_W > RAW_W) ? PH_W : RAW_W;
  localparam int STEPS = ((2 ** RAW_W) - 1) / CLOCK_PERIOD_PS;
  localparam logic [RW-1:0] PERIOD = RW'(CLOCK_PERIOD_PS);

  // Modulo the period by a short chain of conditional subtracts
  function automatic logic [PH_W-1:0] reduce(input logic [RAW_W-1:0] v);
    logic [RW-1:0] acc;
    acc = RW'(v);
    for (int i = 0; i < STEPS; i++) begin
      if (acc >= PERIOD) acc = acc - PERIOD;
    end
    return PH_W'(acc);
  endfunction

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  // Stage register
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      ctx.sec    <= item.seconds_in;
      ctx.nsec   <= NSEC_INT_W'(item.rising_nsec);
      ctx.raw    <= item.meas_phase;
      ctx.ahead  <= item.counter_ahead;
      ctx.fall   <= 1'b0;
      ctx.borrow <= 1'b0;
      ph         <= reduce(item.meas_phase);
      tp_red     <= reduce(tp);
    end
  end

endmodule

/* hdl/rxts_unwrap.sv */
module rxts_unwrap
  import rxts_pkg::*;
#(
  parameter int CLOCK_PERIOD_PS = CLOCK_PERIOD_PS_DEF,
  localparam int PH_W = phase_width(CLOCK_PERIOD_PS)
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  ctx_t            ctx_in,
  input  logic [PH_W-1:0] ph,
  input  logic [PH_W-1:0] tp_red,
  output logic            out_valid,
  input  logic            out_ready,
  output ctx_t            ctx,
  output logic [PH_W-1:0] phase
);

  localparam logic [PH_W-1:0] PERIOD = PH_W'(CLOCK_PERIOD_PS);
  localparam logic [PH_W-1:0] HALF   = PH_W'(CLOCK_PERIOD_PS / 2);
  localparam logic [PH_W-1:0] Q1     = PH_W'(CLOCK_PERIOD_PS / 4);
  localparam logic [PH_W-1:0] Q3     = PH_W'((3 * CLOCK_PERIOD_PS) / 4);
  localparam logic [NSEC_INT_W-1:0] TICK = NSEC_INT_W'(CLOCK_PERIOD_PS / PS_PER_NS);

  logic [PH_W-1:0]       phase_r;
  logic [PH_W-1:0]       sum_f;
  logic [PH_W-1:0]       phase_f;
  logic                  fall;
  logic                  underflow;
  logic [NSEC_INT_W-1:0] nsec_f;
  ctx_t                  ctx_next;

  // Rising and falling phase, each unwrapped into one period
  always_comb begin
    phase_r = (ph >= tp_red) ? ph - tp_red : ph + PERIOD - tp_red;
    sum_f   = phase_r + HALF;
    phase_f = (sum_f >= PERIOD) ? sum_f - PERIOD : sum_f;
    fall    = (phase_r > Q3) || (phase_r < Q1);
  end

  // Falling-edge count, borrowing a second on underflow
  always_comb begin
    underflow = ctx_in.ahead && (ctx_in.nsec < TICK);
    if (underflow) begin
      nsec_f = ctx_in.nsec + (NS_PER_SEC - TICK);
    end else if (ctx_in.ahead) begin
      nsec_f = ctx_in.nsec - TICK;
    end else begin
      nsec_f = ctx_in.nsec;
    end
  end

  // Context handed to the next stage
  always_comb begin
    ctx_next        = ctx_in;
    ctx_next.nsec   = fall ? nsec_f : ctx_in.nsec;
    ctx_next.fall   = fall;
    ctx_next.borrow = fall && underflow;
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      ctx   <= ctx_next;
      phase <= fall ? phase_f : phase_r;
    end
  end

endmodule

/* hdl/rxts_merge.sv */
module rxts_merge
  import rxts_pkg::*;
#(
  parameter int CLOCK_PERIOD_PS = CLOCK_PERIOD_PS_DEF,
  localparam int PH_W = phase_width(CLOCK_PERIOD_PS)
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  ctx_t            ctx_in,
  input  logic [PH_W-1:0] phase_in,
  output logic            out_valid,
  input  logic            out_ready,
  output ctx_t            ctx,
  output logic [PH_W-1:0] phase
);

  localparam logic [PH_W-1:0] PERIOD = PH_W'(CLOCK_PERIOD_PS);
  localparam logic [PH_W-1:0] HALF   = PH_W'(CLOCK_PERIOD_PS / 2);
  localparam logic [NSEC_INT_W-1:0] TICK = NSEC_INT_W'(CLOCK_PERIOD_PS / PS_PER_NS);

  logic [PH_W-1:0] sum;
  logic            wrap;
  logic [PH_W-1:0] phase_sel;
  ctx_t            ctx_next;

  // Falling phase shifted back half a period; a wrap carries one tick
  always_comb begin
    sum  = phase_in + HALF;
    wrap = ctx_in.fall && (sum >= PERIOD);
    if (!ctx_in.fall) begin
      phase_sel = phase_in;
    end else if (wrap) begin
      phase_sel = sum - PERIOD;
    end else begin
      phase_sel = sum;
    end
  end

  // Tick carry and second borrow applied to the context
  always_comb begin
    ctx_next      = ctx_in;
    ctx_next.nsec = wrap ? ctx_in.nsec + TICK : ctx_in.nsec;
    ctx_next.sec  = ctx_in.borrow ? ctx_in.sec - SEC_W'(1) : ctx_in.sec;
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      ctx   <= ctx_next;
      phase <= phase_sel;
    end
  end

endmodule

/* hdl/rxts_carry.sv */
module rxts_carry
  import rxts_pkg::*;
#(
  parameter int CLOCK_PERIOD_PS = CLOCK_PERIOD_PS_DEF,
  localparam int PH_W = phase_width(CLOCK_PERIOD_PS)
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  ctx_t            ctx_in,
  input  logic [PH_W-1:0] phase_in,
  output logic            out_valid,
  input  logic            out_ready,
  output out_t            result
);

  logic over;

  // Nanosecond overflow carries into seconds
  assign over     = ctx_in.nsec >= NS_PER_SEC;
  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      result.seconds_out   <= ctx_in.sec + SEC_W'(over);
      result.nsec_out      <= NSEC_W'(over ? ctx_in.nsec - NS_PER_SEC : ctx_in.nsec);
      result.phase_out     <= RAW_W'(phase_in);
      result.raw_phase_out <= ctx_in.raw;
    end
  end

endmodule

/* tb/tb_top.sv */
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import rxts_pkg::*;

  localparam int CYCLE_LIMIT    = 200000;
  localparam int HOLD_CYCLES    = 60;
  localparam int PHASE_ITEMS    = 130;
  localparam int N_PHASES       = 7;
  localparam int SETTLE_CYCLES  = 8;

  localparam logic [SEC_W-1:0]  SEC_MAX  = '1;
  localparam logic [NSEC_W-1:0] NSEC_TOP = '1;
  localparam logic [RAW_W-1:0]  RAW_TOP  = '1;

  // Expected results of accepted timestamps, oldest first
  class ts_scoreboard;
    logic [RAW_W-1:0] tp;
    out_t             pending_ts[$];
    int               mismatch_count;

    function new();
      tp = '0;
      mismatch_count = 0;
    endfunction

    // Merge coarse count and fine phase the way the block should
    function out_t linearize_ts(in_t x);
      longint           period, half, tick, ns_sec;
      longint           ph, tpr, ph_rise, ph_fall, ns, phase;
      logic [SEC_W-1:0] sec;
      out_t             r;
      period = CLOCK_PERIOD_PS_DEF;
      half   = period / 2;
      tick   = period / PS_PER_NS;
      ns_sec = longint'(NS_PER_SEC);
      sec    = x.seconds_in;
      ph     = longint'(x.meas_phase) % period;
      tpr    = longint'(tp) % period;

      // unwrap for the rising and the falling edge
      ph_rise = ph - tpr;
      if (ph_rise < 0) ph_rise += period;
      ph_fall = ph - tpr + half;
      if (ph_fall < 0) ph_fall += period;
      if (ph_fall >= period) ph_fall -= period;

      if (ph_rise > 3 * period / 4 || ph_rise < period / 4) begin
        // near the counter transition: take the falling edge
        ns = longint'(x.rising_nsec) - (x.counter_ahead ? tick : 0);
        if (ns < 0) begin
          ns += ns_sec;
          sec = sec - 1'b1;
        end
        phase = ph_fall + half;
        if (phase >= period) begin
          phase -= period;
          ns += tick;
        end
      end else begin
        ns    = longint'(x.rising_nsec);
        phase = ph_rise;
      end

      if (ns >= ns_sec) begin
        ns -= ns_sec;
        sec = sec + 1'b1;
      end

      r.seconds_out   = sec;
      r.nsec_out      = ns[NSEC_W-1:0];
      r.phase_out     = phase[RAW_W-1:0];
      r.raw_phase_out = x.meas_phase;
      return r;
    endfunction

    function void note_input(in_t x);
      pending_ts.push_back(linearize_ts(x));
    endfunction

    function void check_result(out_t got);
      out_t want;
      if (pending_ts.size() == 0) begin
        $error("result with no item outstanding: %p", got);
        mismatch_count++;
        return;
      end
      want = pending_ts.pop_front();
      if (got.seconds_out !== want.seconds_out) begin
        $error("seconds_out: expected %0d, actual %0d", want.seconds_out, got.seconds_out);
        mismatch_count++;
      end
      if (got.nsec_out !== want.nsec_out) begin
        $error("nsec_out: expected %0d, actual %0d", want.nsec_out, got.nsec_out);
        mismatch_count++;
      end
      if (got.phase_out !== want.phase_out) begin
        $error("phase_out: expected %0d, actual %0d", want.phase_out, got.phase_out);
        mismatch_count++;
      end
      if (got.raw_phase_out !== want.raw_phase_out) begin
        $error("raw_phase_out: expected %0d, actual %0d",
               want.raw_phase_out, got.raw_phase_out);
        mismatch_count++;
      end
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst;
  logic             item_valid;
  logic             item_stall;
  in_t              item;
  logic             result_valid;
  logic             result_stall;
  out_t             result;
  logic             tp_write_en;
  logic [RAW_W-1:0] tp_write_data;

  ts_scoreboard sb = new();
  bit           send_gaps   = 1'b1;
  bit           recv_stalls = 1'b1;
  bit           hold_req    = 1'b0;
  int           cycle_count = 0;

  rx_timestamp_linearizer u_dut (
    .clk           (clk),
    .rst           (rst),
    .item_valid    (item_valid),
    .item_stall    (item_stall),
    .item          (item),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .result        (result),
    .tp_write_en   (tp_write_en),
    .tp_write_data (tp_write_data)
  );

  always #10 clk = ~clk;

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Accepted items in, accepted results checked
  always @(posedge clk) begin
    if (!rst && item_valid && !item_stall) sb.note_input(item);
    if (!rst && result_valid && !result_stall) sb.check_result(result);
  end

  // Receiver: random stall bursts, plus one long hold-off on request
  initial begin
    result_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        result_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        result_stall <= 1'b0;
        hold_req = 1'b0;
      end else if (recv_stalls && $urandom_range(0, 4) == 0) begin
        result_stall <= 1'b1;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        result_stall <= 1'b0;
      end
    end
  end

  // Offer one item and hold it until taken; maybe idle afterwards
  task automatic send_item(input in_t x);
    item       <= x;
    item_valid <= 1'b1;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    if (send_gaps && $urandom_range(0, 4) == 0) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // Wait for every result, then let the pipeline settle
  task automatic drain();
    while (sb.pending_ts.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_tp(input logic [RAW_W-1:0] v);
    tp_write_en   <= 1'b1;
    tp_write_data <= v;
    @(posedge clk);
    tp_write_en <= 1'b0;
    sb.tp = v;
  endtask

  // Random timestamp, biased towards wraps, borrows and quadrant edges
  function automatic in_t random_ts(input logic [RAW_W-1:0] tp);
    in_t x;
    int  ph;
    case ($urandom_range(0, 7))
      0:       x.seconds_in = '0;
      1:       x.seconds_in = SEC_MAX;
      default: x.seconds_in = SEC_W'({$urandom(), $urandom()});
    endcase
    case ($urandom_range(0, 9))
      0:       x.rising_nsec = NSEC_W'($urandom_range(0, 15));
      1:       x.rising_nsec = NSEC_W'(999999999 - $urandom_range(0, 15));
      2:       x.rising_nsec = NSEC_W'($urandom());
      default: x.rising_nsec = NSEC_W'($urandom_range(0, 999999999));
    endcase
    case ($urandom_range(0, 7))
      0: x.meas_phase = RAW_W'($urandom_range(0, 8191));
      1, 2: begin
        ph = int'(tp) % CLOCK_PERIOD_PS_DEF + 2000 * $urandom_range(0, 3)
             + $urandom_range(0, 4) - 2 + CLOCK_PERIOD_PS_DEF;
        x.meas_phase = RAW_W'(ph % CLOCK_PERIOD_PS_DEF);
      end
      default: x.meas_phase = RAW_W'($urandom_range(0, CLOCK_PERIOD_PS_DEF - 1));
    endcase
    x.counter_ahead = 1'($urandom_range(0, 1));
    return x;
  endfunction

  initial begin
    logic [RAW_W-1:0] tp_plan[N_PHASES];
    tp_plan[0] = 13'd7999;
    tp_plan[1] = RAW_TOP;
    tp_plan[2] = 13'd0;
    tp_plan[3] = 13'd4000;
    tp_plan[4] = 13'd2000;
    tp_plan[5] = RAW_W'($urandom_range(0, 8191));
    tp_plan[6] = RAW_W'($urandom_range(0, 7999));

    rst           <= 1'b1;
    item_valid    <= 1'b0;
    item          <= '0;
    tp_write_en   <= 1'b0;
    tp_write_data <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed items, transition point at its reset value
    send_item('{SEC_W'(0), NSEC_W'(0), RAW_W'(0), 1'b1});         // borrow, seconds wrap down
    send_item('{SEC_MAX, NSEC_W'(999999999), RAW_W'(100), 1'b0}); // carry, seconds wrap up
    send_item('{SEC_MAX, NSEC_TOP, RAW_W'(4000), 1'b0});          // count above one second
    send_item('{SEC_W'(5), NSEC_TOP, RAW_W'(0), 1'b1});
    send_item('{SEC_W'(7), NSEC_W'(12345), RAW_TOP, 1'b0});       // phase above period
    send_item('{SEC_W'(7), NSEC_W'(12345), RAW_W'(8000), 1'b1});
    send_item('{SEC_W'(9), NSEC_W'(500), RAW_W'(1999), 1'b1});    // quadrant edges
    send_item('{SEC_W'(9), NSEC_W'(500), RAW_W'(2000), 1'b1});
    send_item('{SEC_W'(9), NSEC_W'(500), RAW_W'(2001), 1'b0});
    send_item('{SEC_W'(9), NSEC_W'(500), RAW_W'(5999), 1'b1});
    send_item('{SEC_W'(9), NSEC_W'(500), RAW_W'(6000), 1'b0});
    send_item('{SEC_W'(9), NSEC_W'(500), RAW_W'(6001), 1'b1});
    send_item('{SEC_W'(3), NSEC_W'(7), RAW_W'(7000), 1'b1});      // one below a tick
    send_item('{SEC_W'(3), NSEC_W'(8), RAW_W'(7000), 1'b1});      // exactly a tick
    send_item('{SEC_W'(3), NSEC_W'(0), RAW_W'(4000), 1'b1});      // rising edge, flag unused
    send_item('{SEC_MAX, NSEC_W'(999999999), RAW_W'(7999), 1'b0});
    send_item('{SEC_W'(0), NSEC_W'(999999992), RAW_W'(3000), 1'b1});
    send_item('{SEC_MAX, NSEC_W'(0), RAW_W'(8100), 1'b1});
    item_valid <= 1'b0;

    // Random phases, one transition point each
    for (int p = 0; p < N_PHASES; p++) begin
      drain();
      write_tp(tp_plan[p]);
      if (p == 3) begin
        // back-to-back items against a long output hold-off
        send_gaps = 1'b0;
        hold_req  = 1'b1;
      end else begin
        send_gaps = (p != N_PHASES - 1);
      end
      recv_stalls = (p != N_PHASES - 1);
      for (int n = 0; n < PHASE_ITEMS; n++) send_item(random_ts(sb.tp));
      item_valid <= 1'b0;
    end

    drain();
    if (sb.mismatch_count == 0 && sb.pending_ts.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
